@@ design/modular_exponentiation_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Shared property shapes, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// same-cycle implication
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Microcode encoding, program table and shared widths.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int LO_BITS = 32;
    localparam int EXP_W   = 34;
    localparam int CNT_W   = 6;
    localparam int PC_W    = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ZERO,
        OP_RED_BASE,
        OP_EXP_ADD,
        OP_RED_EXP,
        OP_ONE,
        OP_MUL_ACC,
        OP_RED_ACC,
        OP_MUL_SQ,
        OP_RED_SQ,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_MOD_LT2,
        C_EXP_NONNEG,
        C_K_ZERO,
        C_K_EVEN
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ucode;

    typedef struct packed {
        logic start;
        logic full_word;
    } t_rem_cmd;

    localparam logic [PC_W-1:0] PC_LOAD     = 4'd0;
    localparam logic [PC_W-1:0] PC_ZERO     = 4'd1;
    localparam logic [PC_W-1:0] PC_RED_BASE = 4'd2;
    localparam logic [PC_W-1:0] PC_EXP_ADD  = 4'd3;
    localparam logic [PC_W-1:0] PC_EXP_CHK  = 4'd4;
    localparam logic [PC_W-1:0] PC_RED_EXP  = 4'd5;
    localparam logic [PC_W-1:0] PC_ONE      = 4'd6;
    localparam logic [PC_W-1:0] PC_LOOP     = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL_ACC  = 4'd8;
    localparam logic [PC_W-1:0] PC_RED_ACC  = 4'd9;
    localparam logic [PC_W-1:0] PC_MUL_SQ   = 4'd10;
    localparam logic [PC_W-1:0] PC_RED_SQ   = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd12;

    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        unique case (pc)
            PC_LOAD:     w = '{OP_LOAD,     C_NEVER,      PC_LOAD};
            PC_ZERO:     w = '{OP_ZERO,     C_MOD_LT2,    PC_EMIT};
            PC_RED_BASE: w = '{OP_RED_BASE, C_EXP_NONNEG, PC_ONE};
            PC_EXP_ADD:  w = '{OP_EXP_ADD,  C_NEVER,      PC_LOAD};
            PC_EXP_CHK:  w = '{OP_NOP,      C_EXP_NONNEG, PC_ONE};
            PC_RED_EXP:  w = '{OP_RED_EXP,  C_NEVER,      PC_LOAD};
            PC_ONE:      w = '{OP_ONE,      C_NEVER,      PC_LOAD};
            PC_LOOP:     w = '{OP_NOP,      C_K_ZERO,     PC_EMIT};
            PC_MUL_ACC:  w = '{OP_MUL_ACC,  C_K_EVEN,     PC_MUL_SQ};
            PC_RED_ACC:  w = '{OP_RED_ACC,  C_NEVER,      PC_LOAD};
            PC_MUL_SQ:   w = '{OP_MUL_SQ,   C_NEVER,      PC_LOAD};
            PC_RED_SQ:   w = '{OP_RED_SQ,   C_ALWAYS,     PC_LOOP};
            PC_EMIT:     w = '{OP_EMIT,     C_ALWAYS,     PC_LOAD};
            default:     w = '{OP_NOP,      C_ALWAYS,     PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ design/mexp_if.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready interfaces for the operand word and the result word.
// ----------------------------------------------------------------------------
interface mexp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] base;
    logic signed [31:0] exponent;

    modport source  (output valid, output base, output exponent, input ready);
    modport sink    (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if #(
    parameter int MOD_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] power_result;

    modport source  (output valid, output power_result, input ready);
    modport sink    (input valid, input power_result, output ready);
endinterface

@@ design/mexp_rem.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation remainder unit
// Restoring remainder, one dividend bit per cycle, high part preloaded.
// ----------------------------------------------------------------------------
module mexp_rem
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_rem_cmd            i_cmd,
    input  logic [MOD_BITS-1:0] i_hi,
    input  logic [LO_BITS-1:0]  i_lo,
    input  logic [MOD_BITS-1:0] i_div,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_rem
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] r_rem;
    logic [LO_BITS-1:0]  r_lo;

    logic [MOD_BITS:0]   s_trial;
    logic [MOD_BITS:0]   s_diff;
    logic [MOD_BITS-1:0] n_rem;
    logic                s_last;

    assign s_trial = {r_rem, r_lo[LO_BITS-1]};
    assign s_diff  = s_trial - {1'b0, i_div};
    assign n_rem   = (s_trial >= {1'b0, i_div}) ? s_diff[MOD_BITS-1:0]
                                                : s_trial[MOD_BITS-1:0];
    assign s_last  = r_busy && (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= s_last;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.full_word ? CNT_W'(LO_BITS) : CNT_W'(MOD_BITS);
            end else if (r_busy) begin
                r_busy <= !s_last;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= r_lo << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square-and-multiply modulo a configured prime, run by a
// microcoded sequencer over one multiplier and one remainder unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    base (s32), exponent (s32)
//  o_out     out  valid/ready    power_result (MOD_BITS)
//  i_cfg_*   in   wr_en only     modulus (MOD_BITS)
//
//  One word at a time: the next operand word is taken only after the emit step. A negative
//  exponent gets the modulus minus one added, and is reduced modulo that if still negative.
//  A set exponent bit adds a multiply and reduction of the accumulator; a modulus below two
//  emits zero. Each reduction runs on the remainder unit, one dividend bit per cycle.
//  Synchronous active-low reset; modulus resets to 2147483647.
//  A result held by a stalled sink holds the sequencer at its emit step.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [MOD_BITS-1:0] i_cfg_wr_data,
    mexp_in_if.sink             i_in,
    mexp_out_if.source          o_out
);

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(32'h7FFF_FFFF);
    localparam int                  LO_SHIFT  = LO_BITS - MOD_BITS;

    logic [PC_W-1:0]       r_pc,        n_pc;
    logic                  r_red_wait,  n_red_wait;
    logic                  r_out_valid, n_out_valid;
    logic [MOD_BITS-1:0]   r_mod;
    logic [LO_BITS-1:0]    r_base,      n_base;
    logic [EXP_W-1:0]      r_e,         n_e;
    logic [MOD_BITS-1:0]   r_x,         n_x;
    logic [MOD_BITS-1:0]   r_acc,       n_acc;
    logic [2*MOD_BITS-1:0] r_prod,      n_prod;
    logic [MOD_BITS-1:0]   r_out,       n_out;

    t_ucode                s_uc;
    logic                  s_adv;
    logic                  s_take;
    logic                  s_is_red;
    logic                  s_pre_red;
    t_rem_cmd              s_cmd;
    logic [MOD_BITS-1:0]   s_hi;
    logic [LO_BITS-1:0]    s_lo;
    logic [MOD_BITS-1:0]   s_div;
    logic [MOD_BITS-1:0]   s_pm;
    logic [LO_BITS-1:0]    s_abs_b;
    logic [EXP_W-1:0]      s_neg_e;
    logic [MOD_BITS-1:0]   s_mul_a;
    logic                  s_rem_done;
    logic [MOD_BITS-1:0]   s_rem;

    assign s_uc      = ucode_rom(r_pc);
    assign s_pm      = r_mod - MOD_BITS'(1);
    assign s_abs_b   = r_base[LO_BITS-1] ? (LO_BITS'(0) - r_base) : r_base;
    assign s_neg_e   = EXP_W'(0) - r_e;
    assign s_mul_a   = (s_uc.op == OP_MUL_ACC) ? r_acc : r_x;
    assign s_is_red  = s_uc.op inside {OP_RED_BASE, OP_RED_EXP, OP_RED_ACC, OP_RED_SQ};
    assign s_pre_red = s_uc.op inside {OP_RED_BASE, OP_RED_EXP};

    assign s_cmd           = '{start: s_is_red && !r_red_wait, full_word: s_pre_red};
    assign s_hi            = s_pre_red ? '0 : r_prod[2*MOD_BITS-1:MOD_BITS];
    assign s_div           = (s_uc.op == OP_RED_EXP) ? s_pm : r_mod;

    always_comb begin
        case (s_uc.op)
            OP_RED_BASE: s_lo = s_abs_b;
            OP_RED_EXP:  s_lo = s_neg_e[LO_BITS-1:0];
            default:     s_lo = LO_BITS'(r_prod[MOD_BITS-1:0]) << LO_SHIFT;
        endcase
    end

    mexp_rem #(
        .MOD_BITS (MOD_BITS)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_hi    (s_hi),
        .i_lo    (s_lo),
        .i_div   (s_div),
        .o_done  (s_rem_done),
        .o_rem   (s_rem)
    );

    always_comb begin
        unique case (s_uc.cond)
            C_NEVER:      s_take = 1'b0;
            C_ALWAYS:     s_take = 1'b1;
            C_MOD_LT2:    s_take = (r_mod < MOD_BITS'(2));
            C_EXP_NONNEG: s_take = !r_e[EXP_W-1];
            C_K_ZERO:     s_take = (r_e == '0);
            C_K_EVEN:     s_take = !r_e[0];
            default:      s_take = 1'b0;
        endcase
    end

    always_comb begin
        n_base      = r_base;
        n_e         = r_e;
        n_x         = r_x;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        n_red_wait  = r_red_wait;
        s_adv       = 1'b1;

        unique case (s_uc.op) inside
            OP_LOAD: begin
                s_adv  = i_in.valid;
                n_base = i_in.base;
                n_e    = {{(EXP_W-32){i_in.exponent[31]}}, i_in.exponent};
            end
            OP_ZERO:     n_acc = '0;
            OP_ONE:      n_acc = MOD_BITS'(1);
            OP_EXP_ADD:  n_e   = r_e + EXP_W'(s_pm);
            OP_MUL_ACC,
            OP_MUL_SQ:   n_prod = (2*MOD_BITS)'(s_mul_a) * (2*MOD_BITS)'(r_x);
            OP_RED_BASE, OP_RED_EXP, OP_RED_ACC, OP_RED_SQ: begin
                s_adv      = r_red_wait && s_rem_done;
                n_red_wait = !s_adv;
                if (s_adv) begin
                    case (s_uc.op)
                        OP_RED_BASE:
                            n_x = (r_base[LO_BITS-1] && (s_rem != '0)) ? (r_mod - s_rem)
                                                                        : s_rem;
                        OP_RED_EXP:
                            n_e = (s_rem != '0) ? EXP_W'(s_pm - s_rem) : EXP_W'(s_rem);
                        OP_RED_ACC:
                            n_acc = s_rem;
                        default: begin
                            n_x = s_rem;
                            n_e = r_e >> 1;
                        end
                    endcase
                end
            end
            OP_EMIT: begin
                s_adv = !r_out_valid || o_out.ready;
                if (s_adv) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                end
            end
            default: s_adv = 1'b1;
        endcase

        if (!s_adv) begin
            n_pc = r_pc;
        end else if (s_take) begin
            n_pc = s_uc.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_LOAD;
            r_red_wait  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mod       <= MOD_RESET;
        end else begin
            r_pc        <= n_pc;
            r_red_wait  <= n_red_wait;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_mod <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_e    <= n_e;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign i_in.ready         = (r_pc == PC_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.power_result = r_out;

endmodule

@@ design/mexp_checker.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level channels and flags ordering and hold violations.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_macros.svh"

module mexp_checker #(
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [MOD_BITS-1:0] i_out_data
);

    logic s_in_acc;
    logic s_out_stall;
    logic s_idle;

    assign s_in_acc    = i_in_valid && i_in_ready;
    assign s_out_stall = i_out_valid && !i_out_ready;
    assign s_idle      = i_in_ready && !i_in_valid && !i_out_valid;

    // hold a stalled result word
    `MEXP_ASSERT_NXT(a_out_hold, s_out_stall, i_out_valid && $stable(i_out_data), "word lost")

    // drop ready once a word is taken
    `MEXP_ASSERT_NXT(a_in_busy, s_in_acc, !i_in_ready, "operand taken while busy")

    // a new result follows a busy cycle
    `MEXP_ASSERT_IMP(a_out_order, $rose(i_out_valid), !$past(i_in_ready), "result without a word")

    // write configuration only while both channels are idle
    `MEXP_ASSERT_IMP(a_cfg_idle, i_cfg_wr_en, s_idle, "configuration write while busy")

endmodule

bind modular_exponentiation_top mexp_checker #(
    .MOD_BITS (MOD_BITS)
) u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.power_result)
);
